@@ design/svm_pkg.sv @@
package svm_pkg;

    // Store geometry and voice counts
    localparam int NUM_SOUNDS = 16;
    localparam int NUM_MUSIC  = 4;
    localparam int NUM_VOICES = 8;
    localparam int MAX_FRAMES = 16384;

    localparam int SND_W   = 4;
    localparam int FRAME_W = 14;
    localparam int LEN_W   = 15;
    localparam int GAIN_W  = 16;
    localparam int WGT_W   = 17;
    localparam int SMP_W   = 16;
    localparam int ADDR_W  = SND_W + FRAME_W;
    localparam int MUS_W   = (NUM_MUSIC > 1) ? $clog2(NUM_MUSIC) : 1;
    localparam int VOC_W   = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int NUM_SLOTS = NUM_MUSIC + NUM_VOICES;
    localparam int SLOT_W  = $clog2(NUM_SLOTS);
    localparam int PROD_W  = SMP_W + WGT_W + 1;
    localparam int ACC_W   = 40;

    localparam logic [GAIN_W-1:0] UNITY      = 16'd32768;
    localparam logic [WGT_W-1:0]  MIN_WEIGHT = 17'd3;
    localparam logic [LEN_W-1:0]  LEN_MAX    = 15'd16384;

    typedef enum logic [2:0] {
        OP_MIX   = 3'd0,
        OP_PLAY  = 3'd1,
        OP_STOP  = 3'd2,
        OP_WRITE = 3'd3,
        OP_LEN   = 3'd4,
        OP_BASE  = 3'd5,
        OP_GATE  = 3'd6,
        OP_START = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic              accept;
        logic              issue;
        logic [SLOT_W-1:0] slot;
        logic              finish;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } sts_t;

endpackage

@@ design/svm_ram.sv @@
module svm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 262144
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

@@ design/svm_ctrl.sv @@
module svm_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [2:0]    operation,
    input  svm_pkg::sts_t sts,
    output logic          in_stall,
    output svm_pkg::cmd_t cmd
);
    import svm_pkg::*;

    state_t            state_reg, state_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              last_slot;

    assign last_slot = (slot_reg == SLOT_W'(NUM_SLOTS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            slot_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        slot_next  = slot_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                slot_next = '0;
                if (in_valid && (op_t'(operation) == OP_MIX))
                begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                slot_next = slot_reg + 1'b1;
                if (last_slot)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!sts.pipe_busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        in_stall   = 1'b1;
        cmd.accept = 1'b0;
        cmd.issue  = 1'b0;
        cmd.slot   = slot_reg;
        cmd.finish = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
            end
            ST_ISSUE: cmd.issue = 1'b1;
            ST_DRAIN: ;
            ST_DONE:  cmd.finish = sts.out_free;
            default: ;
        endcase
    end

endmodule

@@ design/svm_dp.sv @@
module svm_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  svm_pkg::cmd_t       cmd,
    output svm_pkg::sts_t       sts,
    input  logic [2:0]          operation,
    input  logic [3:0]          sound_id,
    input  logic [13:0]         frame_index,
    input  logic signed [15:0]  left_in,
    input  logic signed [15:0]  right_in,
    input  logic [15:0]         value,
    input  logic                cfg_write,
    input  logic [14:0]         cfg_data,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [15:0]  left_out,
    output logic signed [15:0]  right_out,
    output logic                music_wrapped
);
    import svm_pkg::*;

    // Control and gain state
    logic [LEN_W-1:0]   music_len_reg;
    logic [LEN_W-1:0]   sound_len_reg [NUM_SOUNDS];
    logic [GAIN_W-1:0]  base_reg [NUM_MUSIC];
    logic [GAIN_W-1:0]  gate_reg [NUM_MUSIC];
    logic [FRAME_W-1:0] cursor_reg;
    logic               running_reg;
    logic [NUM_VOICES-1:0] vact_reg;
    logic [SND_W-1:0]   vsnd_reg [NUM_VOICES];
    logic [FRAME_W-1:0] vpos_reg [NUM_VOICES];

    // Pipeline and output
    logic               a_valid_reg, a_incl_reg;
    logic [WGT_W-1:0]   a_weight_reg;
    logic               p_valid_reg;
    logic signed [PROD_W-1:0] p_l_reg, p_r_reg;
    logic signed [ACC_W-1:0]  acc_l_reg, acc_r_reg;
    logic               out_valid_reg;
    logic signed [SMP_W-1:0]  left_reg, right_reg;
    logic               wrap_reg;

    op_t                op;
    logic [GAIN_W-1:0]  gain;
    logic [LEN_W-1:0]   len_in;
    logic               is_music;
    logic [MUS_W-1:0]   mi;
    logic [VOC_W-1:0]   vi;
    logic [SND_W-1:0]   len_addr;
    logic [LEN_W-1:0]   len_rd;
    logic [2*GAIN_W-1:0] wprod;
    logic [WGT_W-1:0]   weight;
    logic               incl;
    logic [LEN_W-1:0]   vpos_inc;
    logic [VOC_W-1:0]   free_v;
    logic               found;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_addr;
    logic [31:0]        ram_rdata;
    logic signed [SMP_W-1:0]  smp_l, smp_r;
    logic signed [WGT_W:0]    wsg;
    logic [LEN_W-1:0]   cur_inc, mlen_eff;

    // Clamp a floored sum to the 16-bit sample range
    function automatic logic signed [SMP_W-1:0] sat16(input logic signed [ACC_W-1:0] x);
        logic signed [SMP_W-1:0] r;
        if (x > ACC_W'(32767))
        begin
            r = 16'sd32767;
        end
        else if (x < -ACC_W'(32768))
        begin
            r = -16'sd32768;
        end
        else
        begin
            r = x[SMP_W-1:0];
        end
        return r;
    endfunction

    assign op       = op_t'(operation);
    assign gain     = (value > UNITY) ? UNITY : value;
    assign len_in   = (value > 16'(LEN_MAX)) ? LEN_MAX : value[LEN_W-1:0];
    assign is_music = (cmd.slot < SLOT_W'(NUM_MUSIC));
    assign mi       = cmd.slot[MUS_W-1:0];
    assign vi       = VOC_W'(cmd.slot - SLOT_W'(NUM_MUSIC));

    // Single length lookup: play check on accept, track or voice sound while issuing
    always_comb
    begin
        if (cmd.issue)
        begin
            len_addr = is_music ? SND_W'(mi) : vsnd_reg[vi];
        end
        else
        begin
            len_addr = sound_id;
        end
    end
    assign len_rd = sound_len_reg[len_addr];

    // Slot weight and inclusion
    assign wprod    = base_reg[mi] * gate_reg[mi];
    assign vpos_inc = {1'b0, vpos_reg[vi]} + 1'b1;
    always_comb
    begin
        if (is_music)
        begin
            weight = wprod[2*GAIN_W-1:GAIN_W-1];
            incl   = running_reg && (weight > MIN_WEIGHT) && (len_rd != '0);
        end
        else
        begin
            weight = WGT_W'(UNITY);
            incl   = vact_reg[vi];
        end
    end

    // First free voice, else voice zero
    always_comb
    begin
        free_v = '0;
        found  = 1'b0;
        for (int v = 0; v < NUM_VOICES; v++)
        begin
            if (!found && !vact_reg[v])
            begin
                free_v = VOC_W'(v);
                found  = 1'b1;
            end
        end
    end

    // Sample store port
    assign ram_we = cmd.accept && (op == OP_WRITE);
    always_comb
    begin
        if (cmd.issue)
        begin
            ram_addr = is_music ? {SND_W'(mi), cursor_reg} : {vsnd_reg[vi], vpos_reg[vi]};
        end
        else
        begin
            ram_addr = {sound_id, frame_index};
        end
    end

    svm_ram #(
        .WIDTH (32),
        .DEPTH (NUM_SOUNDS * MAX_FRAMES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata ({right_in, left_in}),
        .rdata (ram_rdata)
    );

    // Weighted terms
    assign smp_l = a_incl_reg ? signed'(ram_rdata[15:0])  : '0;
    assign smp_r = a_incl_reg ? signed'(ram_rdata[31:16]) : '0;
    assign wsg   = signed'({1'b0, a_weight_reg});

    // Cursor advance
    assign cur_inc  = {1'b0, cursor_reg} + 1'b1;
    assign mlen_eff = (music_len_reg > LEN_MAX) ? LEN_MAX : music_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            music_len_reg <= LEN_MAX;
            for (int s = 0; s < NUM_SOUNDS; s++)
            begin
                sound_len_reg[s] <= '0;
            end
            for (int m = 0; m < NUM_MUSIC; m++)
            begin
                base_reg[m] <= '0;
                gate_reg[m] <= UNITY;
            end
            cursor_reg  <= '0;
            running_reg <= 1'b0;
            vact_reg    <= '0;
            for (int v = 0; v < NUM_VOICES; v++)
            begin
                vsnd_reg[v] <= '0;
                vpos_reg[v] <= '0;
            end
            a_valid_reg   <= 1'b0;
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                music_len_reg <= cfg_data;
            end

            // Requests that edit state
            if (cmd.accept)
            begin
                case (op)
                    OP_PLAY:
                    begin
                        if (len_rd != '0)
                        begin
                            vsnd_reg[free_v] <= sound_id;
                            vpos_reg[free_v] <= '0;
                            vact_reg[free_v] <= 1'b1;
                        end
                    end
                    OP_STOP:
                    begin
                        for (int v = 0; v < NUM_VOICES; v++)
                        begin
                            if (vsnd_reg[v] == sound_id)
                            begin
                                vact_reg[v] <= 1'b0;
                            end
                        end
                    end
                    OP_LEN: sound_len_reg[sound_id] <= len_in;
                    OP_BASE:
                    begin
                        if (32'(sound_id) < NUM_MUSIC)
                        begin
                            base_reg[MUS_W'(sound_id)] <= gain;
                        end
                    end
                    OP_GATE:
                    begin
                        if (32'(sound_id) < NUM_MUSIC)
                        begin
                            gate_reg[MUS_W'(sound_id)] <= gain;
                        end
                    end
                    OP_START:
                    begin
                        cursor_reg  <= '0;
                        running_reg <= 1'b1;
                    end
                    default: ;
                endcase
            end

            // Voice advance at issue
            if (cmd.issue && !is_music && vact_reg[vi])
            begin
                vpos_reg[vi] <= vpos_inc[FRAME_W-1:0];
                if (vpos_inc >= len_rd)
                begin
                    vact_reg[vi] <= 1'b0;
                end
            end

            a_valid_reg <= cmd.issue;
            p_valid_reg <= a_valid_reg;

            // Frame end: cursor and output register
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
                if (running_reg)
                begin
                    if (cur_inc >= mlen_eff)
                    begin
                        cursor_reg <= '0;
                    end
                    else
                    begin
                        cursor_reg <= cur_inc[FRAME_W-1:0];
                    end
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            a_incl_reg   <= incl;
            a_weight_reg <= weight;
        end
        if (a_valid_reg)
        begin
            p_l_reg <= smp_l * wsg;
            p_r_reg <= smp_r * wsg;
        end
        if (cmd.accept)
        begin
            acc_l_reg <= '0;
            acc_r_reg <= '0;
        end
        else if (p_valid_reg)
        begin
            acc_l_reg <= acc_l_reg + ACC_W'(p_l_reg);
            acc_r_reg <= acc_r_reg + ACC_W'(p_r_reg);
        end
        if (cmd.finish)
        begin
            left_reg  <= sat16(acc_l_reg >>> 15);
            right_reg <= sat16(acc_r_reg >>> 15);
            wrap_reg  <= running_reg && (cur_inc >= mlen_eff);
        end
    end

    assign sts.pipe_busy = a_valid_reg || p_valid_reg;
    assign sts.out_free  = !out_valid_reg || !out_stall;

    assign out_valid     = out_valid_reg;
    assign left_out      = left_reg;
    assign right_out     = right_reg;
    assign music_wrapped = wrap_reg;

endmodule

@@ design/stereo_voice_mixer.sv @@
// Channel   Direction  Handshake           Payload
// in        input      in_valid/in_stall   operation sound_id frame_index left_in right_in value
// out       output     out_valid/out_stall left_out right_out music_wrapped
// cfg       input      cfg_write           cfg_data (music loop length)
//
// Edit requests (operations 1 to 7) are accepted while idle and give no result.
// A mix request runs from its accept through these steps: the accept,
// 12 store reads (one per cycle through the single store port), draining the
// read, multiply and accumulate stages, and loading the result register.
// in_stall is high while a mix is in progress; a held result keeps the next mix in its
// last cycle, with in_stall high, until the result is taken. Reset clears voices, sound lengths,
// base gains and cursor (gates to unity, loop length to max); the sample store is not cleared.
module stereo_voice_mixer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         operation,
    input  logic [3:0]         sound_id,
    input  logic [13:0]        frame_index,
    input  logic signed [15:0] left_in,
    input  logic signed [15:0] right_in,
    input  logic [15:0]        value,
    input  logic               cfg_write,
    input  logic [14:0]        cfg_data,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] left_out,
    output logic signed [15:0] right_out,
    output logic               music_wrapped
);
    import svm_pkg::*;

    cmd_t cmd;
    sts_t sts;

    svm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .operation (operation),
        .sts       (sts),
        .in_stall  (in_stall),
        .cmd       (cmd)
    );

    svm_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .operation     (operation),
        .sound_id      (sound_id),
        .frame_index   (frame_index),
        .left_in       (left_in),
        .right_in      (right_in),
        .value         (value),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .left_out      (left_out),
        .right_out     (right_out),
        .music_wrapped (music_wrapped)
    );

endmodule
